>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SHNG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SHNG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/shng_pkg.sv
// Types, sizes and constants of the spatial hash neighbor grid.
package shng_pkg;

  // Table geometry; TABLE_ENTRIES is a power of two
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned CELL_CAPACITY = 8;
  localparam int unsigned OUTPUT_LIMIT  = 64;
  localparam int unsigned MAX_PROBE     = 8;

  localparam int unsigned SLOT_W   = $clog2(TABLE_ENTRIES);
  localparam int unsigned MEMBER_W = $clog2(TABLE_ENTRIES * CELL_CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CELL_CAPACITY + 1);
  localparam int unsigned NUM_W    = $clog2(OUTPUT_LIMIT + 1);
  localparam int unsigned PRB_W    = $clog2(MAX_PROBE + 1);

  localparam int unsigned CS_W    = 31;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned COORD_W = POS_W + 1;
  localparam int unsigned KEY_W   = 64;

  localparam logic [CS_W-1:0]  CELL_SIZE_RESET = CS_W'(65536);
  localparam logic [KEY_W-1:0] MIX1 = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX2 = 64'h3243f6a8885a308d;
  localparam logic [KEY_W-1:0] MIX3 = 64'h243f6a8885a308d3;
  localparam int unsigned      MIX_SHIFT = 32;

  // Action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_CELL_FULL  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

  typedef logic [2:0][POS_W-1:0] pos3_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [ID_W-1:0]         particle_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] neighbor_id;
    logic            has_id;
    logic            last;
    logic [1:0]      status;
    logic            truncated;
  } out_item_t;

  // One hash table slot
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } slot_t;

endpackage

>>> hdl/shng_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read.
module shng_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/shng_div.sv
// Three-lane restoring divider that floors Q16.16 positions by the cell size.
module shng_div import shng_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pos3_t           pos_i,
  input  logic [CS_W-1:0] divisor_i,
  output logic            done_o,
  output pos3_t           coord_o
);

  localparam int unsigned STEP_W = $clog2(POS_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_e;

  dstate_e           state_q;
  logic [STEP_W-1:0] step_q;
  logic              done_q;
  logic [POS_W-1:0]  dvs_q;
  pos3_t             quo_q, rem_q, quo_d, rem_d, fix_d, coord_q;
  logic [2:0]        neg_q;

  // One quotient bit per lane per cycle, then apply the floor correction
  always_comb begin
    logic [POS_W-1:0] sh;
    logic [POS_W:0]   trial;
    for (int l = 0; l < 3; l++) begin
      sh    = {rem_q[l][POS_W-2:0], quo_q[l][POS_W-1]};
      trial = {1'b0, sh} - {1'b0, dvs_q};
      if (!trial[POS_W]) begin
        rem_d[l] = trial[POS_W-1:0];
        quo_d[l] = {quo_q[l][POS_W-2:0], 1'b1};
      end else begin
        rem_d[l] = sh;
        quo_d[l] = {quo_q[l][POS_W-2:0], 1'b0};
      end
      if (!neg_q[l]) begin
        fix_d[l] = quo_q[l];
      end else if (rem_q[l] != '0) begin
        fix_d[l] = ~quo_q[l];
      end else begin
        fix_d[l] = -quo_q[l];
      end
    end
  end

  // Sequence the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      dvs_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      neg_q   <= '0;
      coord_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            for (int l = 0; l < 3; l++) begin
              neg_q[l] <= pos_i[l][POS_W-1];
              quo_q[l] <= pos_i[l][POS_W-1] ? -pos_i[l] : pos_i[l];
            end
            rem_q   <= '0;
            dvs_q   <= {1'b0, divisor_i};
            step_q  <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          quo_q  <= quo_d;
          rem_q  <= rem_d;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(POS_W - 1)) begin
            state_q <= D_FIX;
          end
        end
        D_FIX: begin
          coord_q <= fix_d;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign coord_o = coord_q;

endmodule

>>> hdl/shng_hash.sv
// Cell hash mixer built around one 32x32 multiplier.
module shng_hash import shng_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [COORD_W-1:0] cx_i,
  input  logic [COORD_W-1:0] cy_i,
  input  logic [COORD_W-1:0] cz_i,
  output logic               done_o,
  output logic [KEY_W-1:0]   hash_o
);

  localparam int unsigned HALF = KEY_W / 2;

  typedef enum logic [1:0] {H_IDLE, H_MUL, H_ACC} hstate_e;

  hstate_e          state_q;
  logic [1:0]       term_q, part_q;
  logic             done_q;
  logic [KEY_W-1:0] x_q, y_q, z_q, h_q, acc_q, prod_q;
  logic [KEY_W-1:0] opnd, mconst, acc_d, hx, hd;
  logic [HALF-1:0]  a_part, m_part;

  // Select the operand and constant halves of the current partial product
  always_comb begin
    case (term_q)
      2'd0:    begin opnd = x_q; mconst = MIX2 ^ MIX2 ^ MIX1; end
      2'd1:    begin opnd = y_q; mconst = MIX2; end
      2'd2:    begin opnd = z_q; mconst = MIX3; end
      default: begin opnd = h_q; mconst = MIX1; end
    endcase
    a_part = (part_q == 2'd2) ? opnd[KEY_W-1:HALF] : opnd[HALF-1:0];
    m_part = (part_q == 2'd1) ? mconst[KEY_W-1:HALF] : mconst[HALF-1:0];
  end

  // Accumulate partial products and fold finished terms into the hash
  always_comb begin
    if (part_q == 2'd0) begin
      acc_d = prod_q;
    end else begin
      acc_d = acc_q + {prod_q[HALF-1:0], {HALF{1'b0}}};
    end
    hx = h_q ^ acc_d;
    case (term_q)
      2'd2:    hd = hx ^ (hx >> MIX_SHIFT);
      2'd3:    hd = acc_d ^ (acc_d >> MIX_SHIFT);
      default: hd = hx;
    endcase
  end

  // Sequence multiply and accumulate phases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      term_q  <= '0;
      part_q  <= '0;
      done_q  <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      h_q     <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        H_IDLE: begin
          if (start_i) begin
            x_q     <= {{(KEY_W-COORD_W){cx_i[COORD_W-1]}}, cx_i};
            y_q     <= {{(KEY_W-COORD_W){cy_i[COORD_W-1]}}, cy_i};
            z_q     <= {{(KEY_W-COORD_W){cz_i[COORD_W-1]}}, cz_i};
            h_q     <= '0;
            term_q  <= '0;
            part_q  <= '0;
            state_q <= H_MUL;
          end
        end
        H_MUL: begin
          prod_q  <= KEY_W'(a_part) * KEY_W'(m_part);
          state_q <= H_ACC;
        end
        H_ACC: begin
          acc_q   <= acc_d;
          state_q <= H_MUL;
          if (part_q == 2'd2) begin
            h_q    <= hd;
            part_q <= '0;
            term_q <= term_q + 1'b1;
            if (term_q == 2'd3) begin
              done_q  <= 1'b1;
              state_q <= H_IDLE;
            end
          end else begin
            part_q <= part_q + 1'b1;
          end
        end
        default: state_q <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

>>> hdl/spatial_hash_neighbor_grid.sv
// Spatial hash grid: insert particle ids by cell, query the 27 cells around a point, clear the table.
//
// Usage notes: an insert runs the cell division (start, one quotient bit per cycle with the
// three axes in parallel, the floor correction and the done strobe), the hash (12 partial
// products through one 32x32 multiplier, each multiplied and then accumulated, plus start
// and done), a read and check of each probed slot of the table RAM, and posts the result.
// A query runs the division once and then, for each of the 27 cells, the hash and the
// probed slots, reads each emitted id and posts the final result. A clear, and the pass
// that follows reset, sweeps the 1024-slot table RAM one slot per cycle, during which no
// transaction is accepted. A stalled output delays completion. Results leave through an
// output register, so one new transaction can be taken while the last result of the
// previous one waits.
module spatial_hash_neighbor_grid import shng_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CS_W-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_data_o
);

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_DIV, S_HASH, S_PRB_RD, S_PRB_CHK, S_MEM_RD, S_MEM_CHK, S_FIN
  } state_e;

  state_e             state_q, state_d;
  logic [CS_W-1:0]    cs_q;
  logic [1:0]         act_q, act_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [SLOT_W-1:0]  sweep_q, sweep_d;
  logic               init_q, init_d;
  pos3_t              coord_q, coord_d;
  logic [1:0]         dx_q, dy_q, dz_q, dx_d, dy_d, dz_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [PRB_W-1:0]   prb_q, prb_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, j_q, j_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic               trunc_q, trunc_d;
  logic               pend_q, pend_d;
  logic [ID_W-1:0]    pend_id_q, pend_id_d;
  logic [1:0]         stat_q, stat_d;
  logic               div_start_q, div_start_d, hash_start_q, hash_start_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic               div_done, hash_done, out_free, last_cell, cell_done;
  pos3_t              div_coord;
  logic [KEY_W-1:0]   hash;
  logic [COORD_W-1:0] hx, hy, hz;
  logic [SLOT_W-1:0]  slot_addr;
  slot_t              slot_rd, slot_wr;
  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr;
  logic [MEMBER_W-1:0] mem_raddr, mem_waddr;
  logic [ID_W-1:0]    mem_rd;
  logic               mem_we;
  logic [CNT_W-1:0]   rd_cnt;

  // Hold the cell size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= CELL_SIZE_RESET;
    end else if (cfg_we_i) begin
      cs_q <= cfg_wdata_i;
    end
  end

  shng_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .pos_i     (coord_q),
    .divisor_i ((cs_q == '0) ? CS_W'(1) : cs_q),
    .done_o    (div_done),
    .coord_o   (div_coord)
  );

  // Offset the cell coordinate by -1, 0 or +1 without wrap
  assign hx = {coord_q[0][POS_W-1], coord_q[0]} + COORD_W'(dx_q) - COORD_W'(1);
  assign hy = {coord_q[1][POS_W-1], coord_q[1]} + COORD_W'(dy_q) - COORD_W'(1);
  assign hz = {coord_q[2][POS_W-1], coord_q[2]} + COORD_W'(dz_q) - COORD_W'(1);

  shng_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .cx_i    (hx),
    .cy_i    (hy),
    .cz_i    (hz),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  assign slot_addr = key_q[SLOT_W-1:0] + SLOT_W'(prb_q);
  assign mem_raddr = MEMBER_W'(slot_q) * MEMBER_W'(CELL_CAPACITY) + MEMBER_W'(j_q);

  shng_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH($bits(slot_t))) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wr),
    .raddr_i (slot_addr),
    .rdata_o (slot_rd)
  );

  shng_ram #(.DEPTH(TABLE_ENTRIES * CELL_CAPACITY), .WIDTH(ID_W)) u_member_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (id_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rd)
  );

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_cell = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);
  assign rd_cnt    = (slot_rd.count > CNT_W'(CELL_CAPACITY)) ? CNT_W'(CELL_CAPACITY)
                                                            : slot_rd.count;

  // Walk actions, probes and cells
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    id_d         = id_q;
    sweep_d      = sweep_q;
    init_d       = init_q;
    coord_d      = coord_q;
    dx_d         = dx_q;
    dy_d         = dy_q;
    dz_d         = dz_q;
    key_d        = key_q;
    prb_d        = prb_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    j_d          = j_q;
    num_d        = num_q;
    trunc_d      = trunc_q;
    pend_d       = pend_q;
    pend_id_d    = pend_id_q;
    stat_d       = stat_q;
    div_start_d  = 1'b0;
    hash_start_d = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    slot_we      = 1'b0;
    slot_waddr   = slot_addr;
    slot_wr      = '{valid: 1'b1, key: key_q, count: CNT_W'(1)};
    mem_we       = 1'b0;
    mem_waddr    = MEMBER_W'(slot_addr) * MEMBER_W'(CELL_CAPACITY);
    cell_done    = 1'b0;

    case (state_q)
      S_SWEEP: begin
        slot_we    = 1'b1;
        slot_waddr = sweep_q;
        slot_wr    = '0;
        sweep_d    = sweep_q + 1'b1;
        if (sweep_q == SLOT_W'(TABLE_ENTRIES - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_FIN;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = in_data_i.action;
          id_d    = in_data_i.particle_id;
          coord_d = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
          num_d   = '0;
          trunc_d = 1'b0;
          pend_d  = 1'b0;
          stat_d  = ST_OK;
          if (in_data_i.action == ACT_INSERT || in_data_i.action == ACT_QUERY) begin
            div_start_d = 1'b1;
            state_d     = S_DIV;
          end else if (in_data_i.action == ACT_CLEAR) begin
            sweep_d = '0;
            state_d = S_SWEEP;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          coord_d = div_coord;
          if (act_q == ACT_INSERT) begin
            dx_d = 2'd1;
            dy_d = 2'd1;
            dz_d = 2'd1;
          end else begin
            dx_d = 2'd0;
            dy_d = 2'd0;
            dz_d = 2'd0;
          end
          hash_start_d = 1'b1;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          key_d   = hash;
          prb_d   = '0;
          state_d = S_PRB_RD;
        end
      end
      S_PRB_RD: begin
        state_d = S_PRB_CHK;
      end
      S_PRB_CHK: begin
        if (act_q == ACT_INSERT) begin
          state_d = S_FIN;
          if (!slot_rd.valid) begin
            slot_we = 1'b1;
            mem_we  = 1'b1;
          end else if (slot_rd.key == key_q) begin
            if (slot_rd.count >= CNT_W'(CELL_CAPACITY)) begin
              stat_d = ST_CELL_FULL;
            end else begin
              slot_we       = 1'b1;
              slot_wr.count = slot_rd.count + 1'b1;
              mem_we        = 1'b1;
              mem_waddr     = MEMBER_W'(slot_addr) * MEMBER_W'(CELL_CAPACITY)
                              + MEMBER_W'(slot_rd.count);
            end
          end else if (prb_q == PRB_W'(MAX_PROBE - 1)) begin
            stat_d = ST_TABLE_FULL;
          end else begin
            prb_d   = prb_q + 1'b1;
            state_d = S_PRB_RD;
          end
        end else begin
          // Query: a missing cell moves on to the next one
          cell_done = 1'b1;
          if (slot_rd.valid && slot_rd.key == key_q && rd_cnt != '0) begin
            cell_done = 1'b0;
            slot_d    = slot_addr;
            cnt_d     = rd_cnt;
            j_d       = '0;
            state_d   = S_MEM_RD;
          end else if (slot_rd.valid && slot_rd.key != key_q
                       && prb_q != PRB_W'(MAX_PROBE - 1)) begin
            cell_done = 1'b0;
            prb_d     = prb_q + 1'b1;
            state_d   = S_PRB_RD;
          end
        end
      end
      S_MEM_RD: begin
        if (num_q == NUM_W'(OUTPUT_LIMIT)) begin
          // Output limit reached with ids left: flag and finish
          trunc_d = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_MEM_CHK;
        end
      end
      S_MEM_CHK: begin
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_d = '{neighbor_id: pend_id_q, has_id: 1'b1, last: 1'b0,
                      status: ST_OK, truncated: 1'b0};
          end
          pend_d    = 1'b1;
          pend_id_d = mem_rd;
          num_d     = num_q + 1'b1;
          j_d       = j_q + 1'b1;
          if (j_q + 1'b1 == cnt_q) begin
            cell_done = 1'b1;
          end else begin
            state_d = S_MEM_RD;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{neighbor_id: '0, has_id: 1'b0, last: 1'b1,
                    status: (act_q == ACT_INSERT) ? stat_q : ST_OK, truncated: 1'b0};
          if (act_q == ACT_QUERY && pend_q) begin
            out_d.neighbor_id = pend_id_q;
            out_d.has_id      = 1'b1;
            out_d.truncated   = trunc_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Advance to the next neighbor cell, or finish after the last one
    if (cell_done) begin
      state_d = S_FIN;
      if (!last_cell) begin
        if (dz_q != 2'd2) begin
          dz_d = dz_q + 1'b1;
        end else begin
          dz_d = '0;
          if (dy_q != 2'd2) begin
            dy_d = dy_q + 1'b1;
          end else begin
            dy_d = '0;
            dx_d = dx_q + 1'b1;
          end
        end
        hash_start_d = 1'b1;
        state_d      = S_HASH;
      end
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      init_q       <= 1'b1;
      sweep_q      <= '0;
      div_start_q  <= 1'b0;
      hash_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
      act_q        <= '0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      init_q       <= init_d;
      sweep_q      <= sweep_d;
      div_start_q  <= div_start_d;
      hash_start_q <= hash_start_d;
      out_valid_q  <= out_valid_d;
      act_q        <= act_d;
      pend_q       <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    id_q      <= id_d;
    coord_q   <= coord_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    dz_q      <= dz_d;
    key_q     <= key_d;
    prb_q     <= prb_d;
    slot_q    <= slot_d;
    cnt_q     <= cnt_d;
    j_q       <= j_d;
    num_q     <= num_d;
    trunc_q   <= trunc_d;
    pend_id_q <= pend_id_d;
    stat_q    <= stat_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/shng_checker.sv
// Port-level checks of the spatial hash neighbor grid, bound to the top level.
`include "assert_macros.svh"

module shng_checker import shng_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  `SHNG_ASSERT(a_in_busy, in_valid_i && !in_stall_o |=> in_stall_o, "accepted input without going busy")
  `SHNG_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")
  `SHNG_ASSERT(a_empty_last, out_valid_o && !out_data_o.has_id |-> out_data_o.last && out_data_o.neighbor_id == '0, "empty result is not final")
  `SHNG_ASSERT(a_status_alone, out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last && !out_data_o.has_id && !out_data_o.truncated, "drop status on an id result")
  `SHNG_ASSERT_ALWAYS(a_trunc_final, out_valid_o && out_data_o.truncated |-> out_data_o.last && out_data_o.has_id, "truncation flag off the final id")

endmodule

bind spatial_hash_neighbor_grid shng_checker u_shng_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
